// ----- hdl/edidnp_pkg.sv -----
// Package: beat types, constants and sequencer states for the EDID name parser.
package edidnp_pkg;

    localparam int unsigned NAME_LEN = 13;

    localparam logic [6:0] BLOCK_LAST = 7'd127;
    localparam logic [6:0] HDR_END    = 7'd8;
    localparam logic [6:0] HDR_LAST   = 7'd7;
    localparam logic [6:0] DESC_FIRST = 7'h36;
    localparam logic [6:0] DESC_PRE   = 7'h35;
    localparam logic [6:0] DESC_END   = 7'h7E;

    localparam logic [4:0] DESC_LAST  = 5'd17;
    localparam logic [4:0] OFF_TAG    = 5'd3;
    localparam logic [4:0] OFF_NAME   = 5'd5;

    localparam logic [7:0] NAME_TAG   = 8'hFC;
    localparam logic [7:0] LINE_FEED  = 8'h0A;
    localparam logic [7:0] BYTE_ONES  = 8'hFF;

    localparam logic [3:0] IDX_LAST   = 4'(NAME_LEN - 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_start;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] name_char;
        logic [3:0] char_index;
        logic       checksum_ok;
        logic       header_ok;
        logic       name_found;
        logic       last_char;
    } out_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } state_t;

endpackage

// ----- hdl/edid_block_name_parser_unit.sv -----
// Top level: EDID base block parser with name store in a small synchronous RAM.
//
//  channel  | valid      | stall      | beat       | carries
//  ---------+------------+------------+------------+-------------------------------
//  input    | byte_valid | byte_stall | byte_beat  | data_byte, block_start
//  output   | name_valid | name_stall | name_beat  | name_char, index, flags
//
// One byte is taken per cycle while the sequencer is idle. After byte 127 input
// stalls while the 13 name beats are read out, each by a RAM read and then an
// output register load, and for as long as any output stall holds the load.
// Reset (rst_n, async, active low) clears control state; the RAM is not
// cleared, per-entry valid bits make unwritten entries read as zero.
// A waiting output beat holds the sequencer in its load step; input may resume
// while the final beat still sits in the output register.
module edid_block_name_parser_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  edidnp_pkg::in_beat_t   byte_beat,
    output logic                   name_valid,
    input  logic                   name_stall,
    output edidnp_pkg::out_beat_t  name_beat
);

    // name store RAM, written during the descriptors, read during read-out
    logic [7:0] name_mem [edidnp_pkg::NAME_LEN];
    logic [7:0] rdata_reg;

    // block tracking state
    logic [6:0]                    pos_reg,    pos_next;
    logic [7:0]                    sum_reg,    sum_next;
    logic                          hdr_reg,    hdr_next;
    logic                          zflag_reg,  zflag_next;
    logic                          tmatch_reg, tmatch_next;
    logic                          seen_reg,   seen_next;
    logic [4:0]                    off_reg,    off_next;
    logic [edidnp_pkg::NAME_LEN-1:0] valid_reg, valid_next;

    // read-out sequencer and output register
    edidnp_pkg::state_t            state_reg,  state_next;
    logic [3:0]                    idx_reg,    idx_next;
    logic                          oval_reg,   oval_next;
    edidnp_pkg::out_beat_t         obeat_reg,  obeat_next;

    // RAM port controls
    logic       wr_en;
    logic [3:0] wr_addr;
    logic [7:0] wr_data;
    logic       rd_en;

    // per-byte working values
    logic       take;
    logic       start;
    logic [6:0] p;
    logic [7:0] b;
    logic [7:0] sum_base;
    logic       hdr_base;
    logic       zflag_base;
    logic       tmatch_base;
    logic       seen_base;
    logic       in_desc;

    assign byte_stall = (state_reg != edidnp_pkg::ST_IDLE);
    assign name_valid = oval_reg;
    assign name_beat  = obeat_reg;

    always_comb
    begin
        take  = byte_valid && !byte_stall;
        b     = byte_beat.data_byte;
        start = byte_beat.block_start || (pos_reg == 7'd0);
        p     = start ? 7'd0 : pos_reg;

        // start of block clears all per-block state before the byte is used
        sum_base    = start ? 8'd0 : sum_reg;
        hdr_base    = start ? 1'b1 : hdr_reg;
        zflag_base  = start ? 1'b0 : zflag_reg;
        tmatch_base = start ? 1'b0 : tmatch_reg;
        seen_base   = start ? 1'b0 : seen_reg;

        in_desc = (p >= edidnp_pkg::DESC_FIRST) && (p < edidnp_pkg::DESC_END);

        pos_next    = pos_reg;
        sum_next    = sum_reg;
        hdr_next    = hdr_reg;
        zflag_next  = zflag_reg;
        tmatch_next = tmatch_reg;
        seen_next   = seen_reg;
        off_next    = off_reg;
        valid_next  = valid_reg;
        wr_en       = 1'b0;
        wr_addr     = 4'(off_reg - edidnp_pkg::OFF_NAME);
        wr_data     = (b == edidnp_pkg::LINE_FEED) ? 8'd0 : b;

        state_next  = state_reg;
        idx_next    = idx_reg;
        rd_en       = 1'b0;
        oval_next   = oval_reg && name_stall;
        obeat_next  = obeat_reg;

        unique case (state_reg)
            edidnp_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    sum_next    = sum_base + b;
                    hdr_next    = hdr_base;
                    zflag_next  = zflag_base;
                    tmatch_next = tmatch_base;
                    seen_next   = seen_base;
                    valid_next  = start ? '0 : valid_reg;

                    if (p < edidnp_pkg::HDR_END)
                    begin
                        if (!((b == edidnp_pkg::BYTE_ONES) ||
                              (((p == 7'd0) || (p == edidnp_pkg::HDR_LAST)) &&
                               (b == 8'd0))))
                            hdr_next = 1'b0;
                    end

                    if (in_desc)
                    begin
                        if (off_reg == 5'd0)
                        begin
                            zflag_next  = (b == 8'd0);
                            tmatch_next = 1'b0;
                        end
                        else if (off_reg == edidnp_pkg::OFF_TAG)
                        begin
                            tmatch_next = (b == edidnp_pkg::NAME_TAG);
                            if (zflag_base && (b == edidnp_pkg::NAME_TAG))
                                seen_next = 1'b1;
                        end
                        else if ((off_reg >= edidnp_pkg::OFF_NAME) &&
                                 zflag_base && tmatch_base)
                        begin
                            wr_en               = 1'b1;
                            valid_next[wr_addr] = 1'b1;
                        end
                    end

                    // descriptor offset counter, lined up on the byte before 0x36
                    if ((p == edidnp_pkg::DESC_PRE) || (off_reg == edidnp_pkg::DESC_LAST))
                        off_next = 5'd0;
                    else
                        off_next = off_reg + 5'd1;

                    pos_next = p + 7'd1;

                    if (p == edidnp_pkg::BLOCK_LAST)
                    begin
                        idx_next   = 4'd0;
                        state_next = edidnp_pkg::ST_READ;
                    end
                end
            end

            edidnp_pkg::ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = edidnp_pkg::ST_LOAD;
            end

            edidnp_pkg::ST_LOAD:
            begin
                if (!oval_reg || !name_stall)
                begin
                    oval_next              = 1'b1;
                    obeat_next.name_char   = valid_reg[idx_reg] ? rdata_reg : 8'd0;
                    obeat_next.char_index  = idx_reg;
                    obeat_next.checksum_ok = (sum_reg == 8'd0);
                    obeat_next.header_ok   = hdr_reg;
                    obeat_next.name_found  = seen_reg;
                    obeat_next.last_char   = (idx_reg == edidnp_pkg::IDX_LAST);
                    if (idx_reg == edidnp_pkg::IDX_LAST)
                        state_next = edidnp_pkg::ST_IDLE;
                    else
                    begin
                        idx_next   = idx_reg + 4'd1;
                        state_next = edidnp_pkg::ST_READ;
                    end
                end
            end

            default:
            begin
                state_next = edidnp_pkg::ST_IDLE;
            end
        endcase
    end

    // name store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            name_mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= name_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            sum_reg    <= '0;
            hdr_reg    <= 1'b1;
            zflag_reg  <= 1'b0;
            tmatch_reg <= 1'b0;
            seen_reg   <= 1'b0;
            off_reg    <= '0;
            valid_reg  <= '0;
            state_reg  <= edidnp_pkg::ST_IDLE;
            idx_reg    <= '0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            hdr_reg    <= hdr_next;
            zflag_reg  <= zflag_next;
            tmatch_reg <= tmatch_next;
            seen_reg   <= seen_next;
            off_reg    <= off_next;
            valid_reg  <= valid_next;
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            oval_reg   <= oval_next;
        end
    end

    // output payload holds while stalled; no reset needed
    always_ff @(posedge clk)
    begin
        obeat_reg <= obeat_next;
    end

endmodule

// ----- test/edid_block_name_parser_unit_tb.sv -----
// Self-checking testbench for the EDID block name parser: directed blocks, then random streams.
`timescale 1ns / 1ps

module edid_block_name_parser_unit_tb;

    // descriptor pitch within the base block
    localparam int DESC_SPAN = 18;
    localparam int BLOCK_LEN = 128;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_PRINTS = 100;
    // bytes per idling phase, and bytes in the whole run
    localparam int PHASE_LEN = 140;
    localparam int ITEM_TARGET = 330;

    // how a stimulus block is filled before the header and descriptors are laid on top
    typedef enum logic [1:0] {
        FILL_ZERO,
        FILL_ONES,
        FILL_RAND
    } fill_t;

    // header pattern laid over bytes 0..7
    typedef enum logic [1:0] {
        HDR_KEEP,
        HDR_STD,
        HDR_ONES,
        HDR_BAD
    } hdr_t;

    // one row of the directed set
    typedef struct packed {
        fill_t      fill;
        hdr_t       hdr;
        logic [3:0] name_mask;  // descriptors carrying a proper name entry
        logic [3:0] lead_bad;   // name tag present but first byte non-zero
        logic       fix_sum;    // patch byte 127 so the block sums to zero
        logic       start_mark; // block_start on byte 0 (forced when mid-block)
        logic [6:0] cut;        // bytes sent and abandoned before the real block
        logic       typed;      // expected beats typed in below, not predicted
        logic       exp_chk;
        logic       exp_hdr;
        logic       exp_found;
    } blk_case_t;

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  byte_valid = 1'b0;
    logic                  byte_stall;
    edidnp_pkg::in_beat_t  byte_beat  = '0;
    logic                  name_valid;
    logic                  name_stall = 1'b0;
    edidnp_pkg::out_beat_t name_beat;

    // predictor state
    logic [6:0] cur_pos;
    logic [7:0] cur_sum;
    logic       hdr_fine;
    logic       lead_zero;
    logic       tag_hit;
    logic       name_hit;
    logic [7:0] name_buf [edidnp_pkg::NAME_LEN];

    edidnp_pkg::out_beat_t name_expect_q [$];
    logic                  use_typed = 1'b0;
    blk_case_t             typed_case;

    logic [7:0] blk [BLOCK_LEN];
    int         mismatch_cnt = 0;
    int         bytes_sent = 0;
    int         src_idle_pct = 0;
    int         snk_idle_pct = 0;

    // Directed blocks. The all-zero block has results that are obvious by
    // eye, so its beats are typed in; the other goes through the predictor.
    blk_case_t dir_cases [2] = '{
        // all zero straight after reset: sums to zero, byte 1 breaks the header
        '{FILL_ZERO, HDR_KEEP, 4'b0000, 4'b0000, 1'b0, 1'b1, 7'd0,   1'b1, 1'b1, 1'b0, 1'b0},
        // prefix entered by wrap then abandoned by block_start; two names,
        // the later one must win; tag behind a non-zero first byte
        '{FILL_RAND, HDR_STD,  4'b1010, 4'b0100, 1'b1, 1'b0, 7'd20,  1'b0, 1'b0, 1'b0, 1'b0}
    };

    edid_block_name_parser_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_beat  (byte_beat),
        .name_valid (name_valid),
        .name_stall (name_stall),
        .name_beat  (name_beat)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatch_cnt < MAX_PRINTS)
            $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    // Start-of-block clear: everything the parser accumulates over one block.
    task automatic clear_block();
        int k;
        cur_pos   = 7'd0;
        cur_sum   = 8'h00;
        hdr_fine  = 1'b1;
        lead_zero = 1'b0;
        tag_hit   = 1'b0;
        name_hit  = 1'b0;
        for (k = 0; k < edidnp_pkg::NAME_LEN; k++)
            name_buf[k] = 8'h00;
    endtask

    // Advance the parser model by one accepted byte; on byte 127 queue the
    // thirteen name beats.
    task automatic edid_scan_byte(input edidnp_pkg::in_beat_t b);
        logic [6:0]            p;
        int unsigned           off;
        int                    j;
        edidnp_pkg::out_beat_t r;
        if (b.block_start || cur_pos == 7'd0)
            clear_block();
        p = cur_pos;
        cur_sum = cur_sum + b.data_byte;

        if (p < edidnp_pkg::HDR_END)
        begin
            // ends of the header may be 0x00 or 0xFF, the middle must be 0xFF
            if (!(b.data_byte == edidnp_pkg::BYTE_ONES ||
                  ((p == 7'd0 || p == edidnp_pkg::HDR_LAST) && b.data_byte == 8'h00)))
                hdr_fine = 1'b0;
        end

        if (p >= edidnp_pkg::DESC_FIRST && p < edidnp_pkg::DESC_END)
        begin
            off = (int'(p) - int'(edidnp_pkg::DESC_FIRST)) % DESC_SPAN;
            if (off == 0)
            begin
                // only the first descriptor byte is tested for zero
                lead_zero = (b.data_byte == 8'h00);
                tag_hit   = 1'b0;
            end
            else if (off == edidnp_pkg::OFF_TAG)
            begin
                tag_hit = (b.data_byte == edidnp_pkg::NAME_TAG);
                if (lead_zero && tag_hit)
                    name_hit = 1'b1;
            end
            else if (off >= edidnp_pkg::OFF_NAME && lead_zero && tag_hit)
            begin
                // line feed becomes zero, padding after it is kept as is
                name_buf[off - edidnp_pkg::OFF_NAME] =
                    (b.data_byte == edidnp_pkg::LINE_FEED) ? 8'h00 : b.data_byte;
            end
        end

        if (p == edidnp_pkg::BLOCK_LAST)
        begin
            for (j = 0; j < edidnp_pkg::NAME_LEN; j++)
            begin
                r.char_index = 4'(j);
                r.last_char  = (j == edidnp_pkg::NAME_LEN - 1);
                if (use_typed)
                begin
                    r.name_char   = 8'h00;
                    r.checksum_ok = typed_case.exp_chk;
                    r.header_ok   = typed_case.exp_hdr;
                    r.name_found  = typed_case.exp_found;
                end
                else
                begin
                    r.name_char   = name_buf[j];
                    r.checksum_ok = (cur_sum == 8'h00);
                    r.header_ok   = hdr_fine;
                    r.name_found  = name_hit;
                end
                name_expect_q.push_back(r);
            end
        end

        cur_pos = p + 7'd1;
    endtask

    // Offer one byte, idling first at the current rate, and wait for the beat
    // to be taken. Valid stays high on return so back-to-back beats need no
    // second assignment in the same step. The idling phase follows the byte
    // count: sender mostly busy and receiver mostly stalling, then the other
    // way round, then full rate both sides.
    task automatic send_byte(input edidnp_pkg::in_beat_t b);
        if (bytes_sent < PHASE_LEN)
        begin
            src_idle_pct = 13;
            snk_idle_pct = 69;
        end
        else if (bytes_sent < 2 * PHASE_LEN)
        begin
            src_idle_pct = 69;
            snk_idle_pct = 13;
        end
        else
        begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end
        while ($urandom_range(99) < src_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_beat  <= b;
        do
            @(posedge clk);
        while (byte_stall);
        bytes_sent++;
        edid_scan_byte(b);
    endtask

    task automatic build_block(input blk_case_t c);
        int          i;
        int          d;
        int          k;
        int          base;
        int unsigned pick;
        logic [7:0]  acc;
        for (i = 0; i < BLOCK_LEN; i++)
        begin
            case (c.fill)
                FILL_ZERO: blk[i] = 8'h00;
                FILL_ONES: blk[i] = 8'hFF;
                default:   blk[i] = 8'($urandom_range(255));
            endcase
        end

        case (c.hdr)
            HDR_STD, HDR_BAD:
            begin
                blk[0] = 8'h00;
                for (i = 1; i < 7; i++)
                    blk[i] = edidnp_pkg::BYTE_ONES;
                blk[edidnp_pkg::HDR_LAST] = 8'h00;
                if (c.hdr == HDR_BAD)
                begin
                    // one header byte outside what its position allows
                    k = $urandom_range(7);
                    if (k == 0 || k == edidnp_pkg::HDR_LAST)
                        blk[k] = 8'($urandom_range(1, 254));
                    else
                        blk[k] = 8'($urandom_range(0, 254));
                end
            end
            HDR_ONES:
            begin
                for (i = 0; i < edidnp_pkg::HDR_END; i++)
                    blk[i] = edidnp_pkg::BYTE_ONES;
            end
            default: ;
        endcase

        for (d = 0; d < 4; d++)
        begin
            base = int'(edidnp_pkg::DESC_FIRST) + d * DESC_SPAN;
            if (c.name_mask[d] || c.lead_bad[d])
            begin
                blk[base] = c.name_mask[d] ? 8'h00 : 8'($urandom_range(1, 255));
                blk[base + edidnp_pkg::OFF_TAG] = edidnp_pkg::NAME_TAG;
                for (k = edidnp_pkg::OFF_NAME; k < DESC_SPAN; k++)
                begin
                    pick = $urandom_range(3);
                    if (pick == 0)
                        blk[base + k] = edidnp_pkg::LINE_FEED;
                    else if (pick == 1)
                        blk[base + k] = 8'h20;
                    else
                        blk[base + k] = 8'($urandom_range(255));
                end
            end
            else if (c.fill == FILL_RAND && $urandom_range(2) == 0)
            begin
                // zero lead, some other tag: must not count as a name
                blk[base] = 8'h00;
                blk[base + edidnp_pkg::OFF_TAG] = 8'($urandom_range(254));
                if (blk[base + edidnp_pkg::OFF_TAG] == edidnp_pkg::NAME_TAG)
                    blk[base + edidnp_pkg::OFF_TAG] = 8'hFD;
            end
        end

        if (c.fix_sum)
        begin
            acc = 8'h00;
            for (i = 0; i < edidnp_pkg::BLOCK_LAST; i++)
                acc = acc + blk[i];
            blk[edidnp_pkg::BLOCK_LAST] = 8'h00 - acc;
        end
    endtask

    // Send one case: optional abandoned prefix, then the full 128-byte block.
    task automatic run_case(input blk_case_t c);
        int                   i;
        logic                 lead;
        edidnp_pkg::in_beat_t b;
        build_block(c);
        // a block that does not follow a clean boundary has to be marked
        lead = c.start_mark || (cur_pos != 7'd0);
        if (c.cut != 7'd0)
        begin
            for (i = 0; i < c.cut; i++)
            begin
                b.data_byte   = blk[i];
                b.block_start = lead && (i == 0);
                send_byte(b);
            end
            lead = 1'b1;
        end
        typed_case = c;
        use_typed  = c.typed;
        for (i = 0; i < BLOCK_LEN; i++)
        begin
            b.data_byte   = blk[i];
            b.block_start = lead && (i == 0);
            send_byte(b);
        end
        use_typed = 1'b0;
    endtask

    // Random tail: raw bytes with the odd block_start, up to the byte total.
    task automatic random_phase(input int upto);
        edidnp_pkg::in_beat_t b;
        while (bytes_sent < upto)
        begin
            b.data_byte   = 8'($urandom_range(255));
            b.block_start = ($urandom_range(15) == 0);
            send_byte(b);
        end
    endtask

    // Output side: random stall, and every taken beat checked against the
    // oldest expectation.
    always @(posedge clk)
    begin : name_sink
        edidnp_pkg::out_beat_t want;
        if (rst_n)
        begin
            if (name_valid && !name_stall)
            begin
                if (name_expect_q.size() == 0)
                    report_mismatch("name beat with nothing pending", 32'(name_beat), 32'd0);
                else
                begin
                    want = name_expect_q.pop_front();
                    if (name_beat.name_char != want.name_char)
                        report_mismatch("name_char", 32'(name_beat.name_char),
                                        32'(want.name_char));
                    if (name_beat.char_index != want.char_index)
                        report_mismatch("char_index", 32'(name_beat.char_index),
                                        32'(want.char_index));
                    if (name_beat.checksum_ok != want.checksum_ok)
                        report_mismatch("checksum_ok", 32'(name_beat.checksum_ok),
                                        32'(want.checksum_ok));
                    if (name_beat.header_ok != want.header_ok)
                        report_mismatch("header_ok", 32'(name_beat.header_ok),
                                        32'(want.header_ok));
                    if (name_beat.name_found != want.name_found)
                        report_mismatch("name_found", 32'(name_beat.name_found),
                                        32'(want.name_found));
                    if (name_beat.last_char != want.last_char)
                        report_mismatch("last_char", 32'(name_beat.last_char),
                                        32'(want.last_char));
                end
            end
            name_stall <= ($urandom_range(99) < snk_idle_pct);
        end
    end

    initial
    begin : stimulus
        int i;
        clear_block();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < $size(dir_cases); i++)
            run_case(dir_cases[i]);
        random_phase(ITEM_TARGET);

        byte_valid <= 1'b0;
        while (name_expect_q.size() != 0)
            @(posedge clk);
        // let any stray beat show up before judging
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && name_expect_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
